// File: hw/rtl/mean_green_chromatic_coordinate_assert.svh
// ----------------------------------------------------------------------------
// mean green chromatic coordinate assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef MEAN_GREEN_CHROMATIC_COORDINATE_ASSERT_SVH
`define MEAN_GREEN_CHROMATIC_COORDINATE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MGCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mgcc check failed");

// next-cycle implication, disabled in reset
`define MGCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mgcc check failed");

`endif

// File: hw/rtl/mgcc_pkg.sv
// ----------------------------------------------------------------------------
// mgcc package
// widths, constants and control types of the mean gcc block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mgcc_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int COUNT_BITS    = 24;
  localparam int COLOUR_BITS   = 8;
  localparam int TOTAL_BITS    = COLOUR_BITS + 2;
  localparam int SUM_BITS      = FRACTION_BITS + COUNT_BITS + 1;
  localparam int MEAN_BITS     = FRACTION_BITS + 1;
  localparam int DIV_CNT_BITS  = $clog2(SUM_BITS + 1);
  localparam int IN_DATA_BITS  = 3 * COLOUR_BITS;
  localparam int OUT_RAW_BITS  = MEAN_BITS + COUNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_RAW_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [MEAN_BITS-1:0]  MEAN_ONE  = MEAN_BITS'(1) << FRACTION_BITS;

  typedef struct packed {
    logic accept;
    logic start_pix;
    logic acc;
    logic start_mean;
    logic emit;
  } mgcc_cmd_t;

  typedef struct packed {
    logic pix_used;
    logic last;
    logic div_done;
    logic count_zero;
    logic out_free;
  } mgcc_sts_t;

endpackage

// File: hw/rtl/mean_green_chromatic_coordinate.sv
// ----------------------------------------------------------------------------
// mean green chromatic coordinate
// running mean of green/(red+green+blue) over the non-black pixels of an image
// ----------------------------------------------------------------------------
// pure black pixel, not last: accepted and dropped; counted pixel: divided by the
// one-bit-per-cycle shared divider (41 quotient bits), then accumulated
// last pixel starts the mean division (skipped if no pixel was counted), then emits
// the result word sits in an output register; the next pixel is taken meanwhile
// asynchronous active-low reset clears sum, count, controller and output valid
`timescale 1ns / 1ps

module mean_green_chromatic_coordinate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mgcc_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,  // red, green, blue
  input  logic                                s_axis_tlast,  // last_pixel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mgcc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,  // mean_gcc, pixel_count, pad
  output logic [0:0]                          m_axis_tuser   // no_pixels
);
  import mgcc_pkg::*;

  mgcc_cmd_t cmd;
  mgcc_sts_t sts;
  logic      out_empty;

  mgcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mgcc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_empty_o (out_empty)
  );

  assign m_axis_tuser = out_empty;

endmodule

// File: hw/rtl/mgcc_div.sv
// ----------------------------------------------------------------------------
// mgcc divider
// restoring shift-subtract divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgcc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [mgcc_pkg::SUM_BITS-1:0]     dividend_i,
  input  logic [mgcc_pkg::COUNT_BITS-1:0]   divisor_i,
  output logic [mgcc_pkg::SUM_BITS-1:0]     quotient_o,
  output logic                              done_o
);
  import mgcc_pkg::*;

  logic [SUM_BITS-1:0]     dvd_q, dvd_d;
  logic [COUNT_BITS-1:0]   rem_q, rem_d;
  logic [COUNT_BITS-1:0]   dsr_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    done_q;
  logic [COUNT_BITS:0]     shifted;
  logic [COUNT_BITS:0]     diff;
  logic                    ge;

  assign shifted = {rem_q, dvd_q[SUM_BITS-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign rem_d   = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
  assign dvd_d   = {dvd_q[SUM_BITS-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_CNT_BITS'(SUM_BITS);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == DIV_CNT_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

// File: hw/rtl/mgcc_ctrl.sv
// ----------------------------------------------------------------------------
// mgcc controller
// sequences pixel division, accumulation, mean division and emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgcc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mgcc_pkg::mgcc_sts_t   sts_i,
  output mgcc_pkg::mgcc_cmd_t   cmd_o
);
  import mgcc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX,
    ST_FIN,
    ST_MEAN,
    ST_EMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (sts_i.pix_used) begin
              state_q <= ST_PIX;
            end else if (sts_i.last) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_PIX: begin
          if (sts_i.div_done) begin
            state_q <= sts_i.last ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          state_q <= sts_i.count_zero ? ST_EMIT : ST_MEAN;
        end
        ST_MEAN: begin
          if (sts_i.div_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign cmd_o.accept     = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.start_pix  = (state_q == ST_IDLE) && in_valid_i && sts_i.pix_used;
  assign cmd_o.acc        = (state_q == ST_PIX) && sts_i.div_done;
  assign cmd_o.start_mean = (state_q == ST_FIN) && !sts_i.count_zero;
  assign cmd_o.emit       = (state_q == ST_EMIT) && sts_i.out_free;

endmodule

// File: hw/rtl/mgcc_dp.sv
// ----------------------------------------------------------------------------
// mgcc datapath
// ratio sum, pixel count, shared divider and output word register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgcc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mgcc_pkg::IN_DATA_BITS-1:0]   in_data_i,
  input  logic                                in_last_i,
  input  mgcc_pkg::mgcc_cmd_t                 cmd_i,
  output mgcc_pkg::mgcc_sts_t                 sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mgcc_pkg::OUT_DATA_BITS-1:0]  out_data_o,
  output logic                                out_empty_o
);
  import mgcc_pkg::*;

  logic [COLOUR_BITS-1:0] red, green, blue;
  logic [TOTAL_BITS-1:0]  total;
  logic [SUM_BITS-1:0]    sum_q;
  logic [COUNT_BITS-1:0]  count_q;
  logic                   last_q;
  logic                   out_valid_q;
  logic [MEAN_BITS-1:0]   out_mean_q;
  logic [COUNT_BITS-1:0]  out_count_q;
  logic                   out_empty_q;
  logic                   div_start;
  logic [SUM_BITS-1:0]    div_dividend;
  logic [COUNT_BITS-1:0]  div_divisor;
  logic [SUM_BITS-1:0]    quotient;
  logic                   div_done;

  assign red   = in_data_i[COLOUR_BITS-1:0];
  assign green = in_data_i[2*COLOUR_BITS-1:COLOUR_BITS];
  assign blue  = in_data_i[3*COLOUR_BITS-1:2*COLOUR_BITS];
  assign total = TOTAL_BITS'(red) + TOTAL_BITS'(green) + TOTAL_BITS'(blue);

  assign div_start    = cmd_i.start_pix || cmd_i.start_mean;
  assign div_dividend = cmd_i.start_mean ? sum_q : (SUM_BITS'(green) << FRACTION_BITS);
  assign div_divisor  = cmd_i.start_mean ? count_q : COUNT_BITS'(total);

  mgcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= in_last_i;
      end
      if (cmd_i.acc) begin
        sum_q   <= sum_q + quotient;
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.emit) begin
        sum_q       <= '0;
        count_q     <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_mean_q  <= (count_q == '0) ? '0 : quotient[MEAN_BITS-1:0];
      out_count_q <= count_q;
      out_empty_q <= (count_q == '0);
    end
  end

  // pixel is used when not pure black and the count has room
  assign sts_o.pix_used   = ((red | green | blue) != '0) && (count_q != COUNT_MAX);
  assign sts_o.last       = cmd_i.accept ? in_last_i : last_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{OUT_PAD_BITS{1'b0}}, out_count_q, out_mean_q};
  assign out_empty_o = out_empty_q;

endmodule

// File: hw/rtl/mgcc_checker.sv
// ----------------------------------------------------------------------------
// mgcc checker
// port-level checks on the result stream of the mean gcc block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mean_green_chromatic_coordinate_assert.svh"

module mgcc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [mgcc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input logic [0:0]                          m_axis_tuser
);
  import mgcc_pkg::*;

  logic [MEAN_BITS-1:0]  mean;
  logic [COUNT_BITS-1:0] count;

  assign mean  = m_axis_tdata[MEAN_BITS-1:0];
  assign count = m_axis_tdata[OUT_RAW_BITS-1:MEAN_BITS];

  `MGCC_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `MGCC_ASSERT_NOW(a_empty_zero, m_axis_tvalid && m_axis_tuser[0], mean == '0 && count == '0)
  `MGCC_ASSERT_NOW(a_count_set, m_axis_tvalid && !m_axis_tuser[0], count != '0)
  `MGCC_ASSERT_NOW(a_mean_range, m_axis_tvalid, mean <= MEAN_ONE)

endmodule

bind mean_green_chromatic_coordinate mgcc_checker u_mgcc_checker (.*);
